FILE: rtl/core/tli_pkg.sv
`default_nettype none
package tli_pkg;

  // Status codes of a result.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_ZERO_DX = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  localparam int IDX_OUT_W = 8;

  // Fraction bits of every value; the scale cancels in product and quotient.
  localparam int FRAC_BITS = 16;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_SEG,
    S_RD_LO,
    S_RD_HI,
    S_RD_IDX,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } tli_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic capture;
    logic scan_start;
    logic scan_step;
    logic seg_pick;
    logic rd_lo;
    logic rd_hi;
    logic rd_idx;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic finish;
  } tli_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic mul_done;
    logic div_done;
  } tli_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/tli_if.sv
`default_nettype none
interface tli_in_if #(parameter int VW = 48) ();
  logic valid;
  logic ready;
  logic mode;
  logic first;
  logic signed [VW-1:0] x_value;
  logic signed [VW-1:0] y_value;
  modport source(output valid, mode, first, x_value, y_value, input ready);
  modport sink(input valid, mode, first, x_value, y_value, output ready);
endinterface

interface tli_out_if #(parameter int VW = 48) ();
  logic valid;
  logic ready;
  logic signed [VW-1:0] result;
  logic [1:0] status;
  logic [7:0] nearest_index;
  modport source(output valid, result, status, nearest_index, input ready);
  modport sink(input valid, result, status, nearest_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/table_linear_interpolator.sv
`default_nettype none
// A query scans the N stored entries for the nearest point, reading one entry per
// cycle, then interpolates; the divider makes one bit per cycle.
// One item is in work at a time: no new request is taken until the result is accepted.
// Reset (synchronous, rst_n low) empties the table; stored samples are not cleared.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 48
) (
  input wire logic clk,
  input wire logic rst_n,
  tli_in_if.sink   in_ch,
  tli_out_if.source out_ch
);
  import tli_pkg::*;

  tli_cmd_t  cmd;
  tli_stat_t stat;
  logic few, zero_dx;

  tli_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_mode(in_ch.mode), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .few(few), .zero_dx(zero_dx), .stat(stat), .cmd(cmd)
  );

  tli_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_first(in_ch.first), .in_x(in_ch.x_value), .in_y(in_ch.y_value),
    .stat(stat), .few(few), .zero_dx(zero_dx),
    .result(out_ch.result), .status(out_ch.status),
    .nearest_index(out_ch.nearest_index)
  );

`ifndef SYNTHESIS
  // No new request is taken while a result waits.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  // A query always starts the scan.
  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.mode) |-> cmd.scan_start)
    else $error("query without scan");
  // A load never produces a result next cycle.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !in_ch.mode) |=> !out_ch.valid)
    else $error("load produced a result");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/tli_ctrl.sv
`default_nettype none
module tli_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              few,
  input  wire logic              zero_dx,
  input  wire tli_pkg::tli_stat_t stat,
  output tli_pkg::tli_cmd_t      cmd
);
  import tli_pkg::*;

  tli_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.capture = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        cmd.scan_step = 1'b1;
        state_nxt = few ? S_OUT : S_SEG;
      end
      S_SEG: begin
        cmd.seg_pick = 1'b1;
        state_nxt = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = S_RD_IDX;
      end
      S_RD_IDX: begin
        cmd.rd_idx = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (zero_dx) begin
          cmd.finish = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.mul_step = 1'b1;
          if (stat.mul_done) begin
            cmd.div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/tli_dp.sv
`default_nettype none
module tli_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tli_pkg::tli_cmd_t             cmd,
  input  wire logic                          in_first,
  input  wire logic signed [VALUE_WIDTH-1:0] in_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_y,
  output tli_pkg::tli_stat_t                 stat,
  output logic                               few,
  output logic                               zero_dx,
  output logic signed [VALUE_WIDTH-1:0]      result,
  output logic [1:0]                         status,
  output logic [7:0]                         nearest_index
);
  import tli_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * VW;
  localparam int MW = (VW + 1) / 2;
  localparam int DCW = $clog2(PW + 1);
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Sample stores, one read port each.
  logic [VW-1:0] xs_mem [TABLE_DEPTH];
  logic [VW-1:0] ys_mem [TABLE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] xs_q_r, ys_q_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] wr_pos;
  logic [VW-1:0] q_r;
  logic [CW-1:0] scan_r;
  logic          scan_vld_r;
  logic [AW-1:0] scan_idx_r;
  logic [VW:0]   best_r;
  logic [VW-1:0] best_x_r;
  logic          best_any_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] seg_lo_r;
  logic [VW-1:0] x_lo_r, y_lo_r;
  logic [VW:0]   dxm_r, dym_r, qm_r;
  logic          dxn_r, dyn_r, qn_r;
  logic [VW-1:0] y_idx_r;
  logic [PW-1:0] prod_r;
  logic          mul_phase_r;
  logic [PW-1:0] quo_r;
  logic [VW:0]   rem_r;
  logic [DCW-1:0] dcnt_r;
  logic [VW-1:0] res_r;
  logic [1:0]    status_r;

  // Table write on load.
  assign wr_pos = in_first ? '0 : count_r;
  always_comb begin
    count_nxt = count_r;
    if (cmd.load && (in_first || count_r < CW'(TABLE_DEPTH))) begin
      count_nxt = wr_pos + CW'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load && (in_first || count_r < CW'(TABLE_DEPTH))) begin
      xs_mem[wr_pos[AW-1:0]] <= in_x;
      ys_mem[wr_pos[AW-1:0]] <= in_y;
    end
    xs_q_r <= xs_mem[rd_addr];
    ys_q_r <= ys_mem[rd_addr];
  end

  // Lower end of the segment next to the nearest entry.
  function automatic logic [AW-1:0] seg_lo_nxt_f();
    logic below;
    logic [AW-1:0] lo;
    below = $signed(q_r) < $signed(best_x_r);
    if (below) begin
      lo = (idx_r != '0) ? idx_r - AW'(1) : '0;
    end else begin
      lo = ({1'b0, idx_r} + CW'(1) < count_r) ? idx_r : idx_r - AW'(1);
    end
    return lo;
  endfunction

  // Read address selection.
  always_comb begin
    rd_addr = scan_r[AW-1:0];
    if (cmd.seg_pick) begin
      rd_addr = seg_lo_nxt_f();
    end else if (cmd.rd_lo) begin
      rd_addr = seg_lo_r + AW'(1);
    end else if (cmd.rd_hi) begin
      rd_addr = idx_r;
    end
  end

  // Magnitude of a signed difference.
  function automatic logic [VW:0] dmag(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic signed [VW:0] d;
    d = $signed({a[VW-1], a}) - $signed({b[VW-1], b});
    return d[VW] ? -d : d;
  endfunction

  logic [VW:0] scan_d;
  assign scan_d = dmag(q_r, xs_q_r);
  assign few = count_r < CW'(2);
  assign stat.scan_done = ({1'b0, scan_r} + (CW+1)'(1) >= {1'b0, count_r}) || few;

  // Nearest point scan: one entry read per cycle, compare the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r <= in_x;
    end
    if (cmd.scan_start) begin
      scan_r <= '0;
      scan_vld_r <= 1'b0;
      best_any_r <= 1'b0;
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + CW'(1);
      scan_idx_r <= scan_r[AW-1:0];
      scan_vld_r <= scan_r < count_r;
      if (scan_vld_r && (!best_any_r || scan_d <= best_r)) begin
        best_r <= scan_d;
        best_x_r <= xs_q_r;
        best_any_r <= 1'b1;
        idx_r <= scan_idx_r;
      end
    end
    if (cmd.seg_pick) begin
      seg_lo_r <= seg_lo_nxt_f();
    end
    if (cmd.rd_lo) begin
      x_lo_r <= xs_q_r;
      y_lo_r <= ys_q_r;
    end
    if (cmd.rd_hi) begin
      dxm_r <= dmag(xs_q_r, x_lo_r);
      dxn_r <= $signed(xs_q_r) < $signed(x_lo_r);
      dym_r <= dmag(ys_q_r, y_lo_r);
      dyn_r <= $signed(ys_q_r) < $signed(y_lo_r);
    end
    if (cmd.rd_idx) begin
      y_idx_r <= ys_q_r;
      qm_r <= dmag(q_r, xs_q_r);
      qn_r <= $signed(q_r) < $signed(xs_q_r);
    end
  end
  assign zero_dx = (dxm_r == '0);

  // Product in two halves of the multiplier operand.
  logic [MW-1:0] mpart;
  logic [VW+MW:0] pp;
  assign mpart = mul_phase_r ? MW'(dym_r >> MW) : dym_r[MW-1:0];
  assign pp = qm_r * mpart;
  assign stat.mul_done = mul_phase_r;
  always_ff @(posedge clk) begin
    if (cmd.rd_idx) begin
      mul_phase_r <= 1'b0;
      prod_r <= '0;
    end else if (cmd.mul_step) begin
      mul_phase_r <= 1'b1;
      if (mul_phase_r) begin
        prod_r <= prod_r + (PW'(pp) << MW);
      end else begin
        prod_r <= PW'(pp);
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  logic [VW+1:0] rem_sh;
  logic [VW+1:0] rem_sub;
  assign rem_sh = {rem_r, quo_r[PW-1]};
  assign rem_sub = rem_sh - {1'b0, dxm_r};
  assign stat.div_done = (dcnt_r == DCW'(1));
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= prod_r + (PW'(pp) << MW);
      rem_r <= '0;
      dcnt_r <= DCW'(PW);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCW'(1);
      if (!rem_sub[VW+1]) begin
        rem_r <= rem_sub[VW:0];
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[VW:0];
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
    end
  end

  // Final sum with saturation, or the nearest sample's y on zero spacing.
  logic neg;
  logic signed [PW+1:0] sum;
  assign neg = (qn_r ^ dyn_r) ^ dxn_r;
  assign sum = neg ? $signed({{2{y_idx_r[VW-1]}}, {VW{y_idx_r[VW-1]}}, y_idx_r}) -
                     $signed({2'b00, quo_r})
                   : $signed({{2{y_idx_r[VW-1]}}, {VW{y_idx_r[VW-1]}}, y_idx_r}) +
                     $signed({2'b00, quo_r});
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      res_r <= '0;
      status_r <= ST_FEW;
    end else if (cmd.finish) begin
      if (zero_dx) begin
        res_r <= y_idx_r;
        status_r <= ST_ZERO_DX;
      end else if (sum > $signed({{(PW-VW+2){1'b0}}, VMAX})) begin
        res_r <= VMAX;
        status_r <= ST_SAT;
      end else if (sum < $signed({{(PW-VW+2){1'b1}}, VMIN})) begin
        res_r <= VMIN;
        status_r <= ST_SAT;
      end else begin
        res_r <= sum[VW-1:0];
        status_r <= ST_OK;
      end
    end
  end

  assign result = res_r;
  assign status = status_r;
  assign nearest_index = (AW >= IDX_OUT_W) ? IDX_OUT_W'(idx_r)
                                           : IDX_OUT_W'({{IDX_OUT_W{1'b0}}, idx_r});
endmodule
`default_nettype wire

FILE: tb/sv/tli_tb_pkg.sv
`timescale 1ns / 100ps
package tli_tb_pkg;

  // Request kinds on the input channel.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int VW = 48;
  localparam int DEPTH = 256;

endpackage

FILE: tb/sv/tli_interp_checker.sv
`timescale 1ns / 100ps
module tli_interp_checker
  import tli_pkg::*;
  import tli_tb_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  tli_in_if  in_ch,
  tli_out_if out_ch,
  output int fail_count,
  output int pending_count
);

  typedef struct packed {
    logic signed [VW-1:0] result;
    logic [1:0] status;
    logic [7:0] nearest_index;
  } interp_result_t;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // Shadow copy of the sample table.
  logic signed [VW-1:0] x_table [DEPTH];
  logic signed [VW-1:0] y_table [DEPTH];
  int sample_count;
  interp_result_t expected_results [$];

  // Magnitude of a - b and its sign, with one extra bit of width.
  function automatic logic [VW:0] span(input logic signed [VW-1:0] a,
                                       input logic signed [VW-1:0] b,
                                       output logic neg);
    logic signed [VW:0] t;
    t = $signed({a[VW-1], a}) - $signed({b[VW-1], b});
    neg = t[VW];
    return neg ? -t : t;
  endfunction

  // Interpolated value of the current table at point q.
  function automatic interp_result_t interpolate(input logic signed [VW-1:0] q);
    interp_result_t r;
    logic [VW:0] d, best, dxm, dym, qm;
    logic dxn, dyn, qn, n0;
    int idx, lo_i, hi_i;
    logic [127:0] prod, quot;
    logic signed [131:0] total;
    best = '1;
    idx = 0;
    r = '0;
    for (int i = 0; i < sample_count; i++) begin
      d = span(q, x_table[i], n0);
      if (d <= best) begin
        best = d;
        idx = i;
      end
    end
    r.nearest_index = idx[7:0];
    if (sample_count < 2) begin
      r.status = ST_FEW;
      return r;
    end
    // Left segment when the nearest point lies above the query, else right.
    if (q < x_table[idx]) lo_i = (idx > 0) ? idx - 1 : 0;
    else lo_i = (idx < sample_count - 1) ? idx : idx - 1;
    hi_i = lo_i + 1;
    dxm = span(x_table[hi_i], x_table[lo_i], dxn);
    dym = span(y_table[hi_i], y_table[lo_i], dyn);
    if (dxm == 0) begin
      r.result = y_table[idx];
      r.status = ST_ZERO_DX;
      return r;
    end
    qm = span(q, x_table[idx], qn);
    prod = 128'(qm) * 128'(dym);
    quot = prod / 128'(dxm);
    if ((qn ^ dyn) ^ dxn) total = 132'(y_table[idx]) - $signed({4'b0, quot});
    else total = 132'(y_table[idx]) + $signed({4'b0, quot});
    r.status = ST_OK;
    if (total > 132'(VAL_MAX)) begin
      r.result = VAL_MAX;
      r.status = ST_SAT;
    end else if (total < 132'(VAL_MIN)) begin
      r.result = VAL_MIN;
      r.status = ST_SAT;
    end else begin
      r.result = total[VW-1:0];
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // Track accepted requests and compare accepted results.
  always @(posedge clk) begin
    interp_result_t e;
    if (!rst_n) begin
      sample_count = 0;
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_LOAD) begin
          if (in_ch.first) begin
            x_table[0] = in_ch.x_value;
            y_table[0] = in_ch.y_value;
            sample_count = 1;
          end else if (sample_count < DEPTH) begin
            x_table[sample_count] = in_ch.x_value;
            y_table[sample_count] = in_ch.y_value;
            sample_count = sample_count + 1;
          end
        end else begin
          expected_results.insert(expected_results.size(), interpolate(in_ch.x_value));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no query pending: result=%0d status=%0d",
                 out_ch.result, out_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.result !== e.result || out_ch.status !== e.status ||
              out_ch.nearest_index !== e.nearest_index) begin
            fail_count <= fail_count + 1;
            if (out_ch.result !== e.result)
              $error("result: expected %0d, actual %0d", e.result, out_ch.result);
            if (out_ch.status !== e.status)
              $error("status: expected %0d, actual %0d", e.status, out_ch.status);
            if (out_ch.nearest_index !== e.nearest_index)
              $error("nearest_index: expected %0d, actual %0d",
                     e.nearest_index, out_ch.nearest_index);
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_table_linear_interpolator.sv
`timescale 1ns / 100ps
module tb_table_linear_interpolator;
  import tli_pkg::*;
  import tli_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  logic clk;
  logic rst_n;
  int fail_count;
  int pending_count;
  int cycle_count;
  int sent_count;
  int out_stall;
  bit no_idle;

  tli_in_if #(.VW(VW)) in_ch ();
  tli_out_if #(.VW(VW)) out_ch ();

  table_linear_interpolator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  tli_interp_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.first = 1'b0;
    in_ch.x_value = '0;
    in_ch.y_value = '0;
    out_ch.ready = 1'b0;
    out_stall = 0;
    no_idle = 1'b0;
    cycle_count = 0;
  end

  // Global timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result-side back pressure: mostly short stalls, a few long ones.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (!no_idle && r < 25) begin
      out_ch.ready <= 1'b0;
      out_stall <= (r < 2) ? $urandom_range(20, 120) : $urandom_range(0, 4);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VW-1:0] any_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return VAL_MAX;
    if (r == 1) return VAL_MIN;
    if (r < 5) return VW'($signed($urandom_range(0, 2000)) - 1000);
    return {$urandom, $urandom};
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic m, input logic f,
                              input logic [VW-1:0] x, input logic [VW-1:0] y);
    int gap;
    logic rdy;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.first <= f;
    in_ch.x_value <= x;
    in_ch.y_value <= y;
    forever begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
      if (rdy) break;
    end
    sent_count++;
  endtask

  // Stop sending and wait until every expected result has come.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  // A table of up to n points, mostly on a rough grid, then a few queries.
  task automatic run_table(input int n);
    logic signed [VW-1:0] base, step, x, y, q;
    int kind;
    kind = $urandom_range(0, 3);
    base = (kind == 0) ? any_value() : VW'($signed($urandom_range(0, 4000)) - 2000);
    step = (kind == 1) ? VW'({$urandom} & 32'h00ffffff) : VW'($urandom_range(0, 300));
    for (int i = 0; i < n; i++) begin
      x = base + VW'(i) * step + VW'($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) x = any_value();
      y = ($urandom_range(0, 3) == 0) ? any_value() : VW'({$urandom} & 32'h0fffffff);
      send_request(MODE_LOAD, (i == 0) || ($urandom_range(0, 199) == 0), x, y);
    end
    repeat ($urandom_range(1, 6)) begin
      q = ($urandom_range(0, 4) == 0) ? any_value()
          : base + VW'($signed($urandom_range(0, n * 300 + 600)) - 300);
      send_request(MODE_QUERY, 1'($urandom), q, {$urandom, $urandom});
    end
  endtask

  initial begin
    int r;
    sent_count = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty and single-point tables.
    send_request(MODE_QUERY, 1'b0, '0, '0);
    send_request(MODE_LOAD, 1'b1, '0, '0);
    send_request(MODE_QUERY, 1'b1, VAL_MAX, VAL_MIN);
    // Saturation in both directions.
    send_request(MODE_LOAD, 1'b0, VW'(1), VAL_MAX);
    send_request(MODE_QUERY, 1'b0, VAL_MAX, '0);
    send_request(MODE_QUERY, 1'b0, VAL_MIN, '0);
    send_request(MODE_QUERY, 1'b0, VW'(1), '0);
    // Repeated abscissa: later entry wins, zero spacing.
    send_request(MODE_LOAD, 1'b1, VW'(5), VW'(7));
    send_request(MODE_LOAD, 1'b0, VW'(5), VW'(9));
    send_request(MODE_QUERY, 1'b0, VW'(5), '0);
    send_request(MODE_QUERY, 1'b0, VW'(2), '0);
    // Full-range extremes of both fields.
    send_request(MODE_LOAD, 1'b1, VAL_MIN, VAL_MAX);
    send_request(MODE_LOAD, 1'b0, VAL_MAX, VAL_MIN);
    send_request(MODE_QUERY, 1'b0, '0, '0);
    send_request(MODE_QUERY, 1'b0, VAL_MIN, '0);
    send_request(MODE_QUERY, 1'b0, VAL_MAX, '1);
    send_request(MODE_QUERY, 1'b0, VW'(-1), '0);
    // Rounding toward zero on a negative slope.
    send_request(MODE_LOAD, 1'b1, '0, VW'(10));
    send_request(MODE_LOAD, 1'b0, VW'(3), VW'(0));
    send_request(MODE_QUERY, 1'b0, VW'(1), '0);
    send_request(MODE_QUERY, 1'b0, VW'(-4), '0);
    drain();

    // Random tables: mostly small, a few overfilled past the depth.
    while (sent_count < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) run_table(DEPTH + $urandom_range(0, 6));
      else if (r < 10) run_table(1);
      else if (r < 15) begin
        // Noise: stray loads and bare queries on whatever table is there.
        repeat ($urandom_range(1, 4))
          send_request(1'($urandom), 1'($urandom), any_value(), any_value());
      end else run_table($urandom_range(2, 16));
      if (r == 50) begin
        drain();
      end
    end
    no_idle = 1'b0;
    drain();

    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tli_pkg.sv
rtl/core/tli_if.sv
rtl/core/tli_ctrl.sv
rtl/core/tli_dp.sv
rtl/core/table_linear_interpolator.sv
tb/sv/tli_tb_pkg.sv
tb/sv/tli_interp_checker.sv
tb/sv/tb_table_linear_interpolator.sv
